/* rtl/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  // Lengths and counts run from 0 to 16.
  localparam int CNT_W     = 5;
  // Byte slots in the pattern and replacement registers.
  localparam int SLOT_N    = 16;
  localparam int SLOT_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO,
    CFG_PAT_HI,
    CFG_PAT_LEN,
    CFG_REP_LO,
    CFG_REP_HI,
    CFG_REP_LEN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPL,
    S_DRAIN,
    S_MARK
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit;
    logic from_repl;
    logic mark;
  } sfr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_last;
    logic match;
    logic rlen_zero;
    logic last_q;
    logic idx_end;
  } sfr_stat_t;

endpackage

`default_nettype wire

/* rtl/sfr_if.sv */
`default_nettype none

interface sfr_in_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              text_end;
  logic              run_last;

  modport source (output valid, output out_byte, output byte_valid, output text_end,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input text_end,
                  input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/sfr_ctrl.sv */
`default_nettype none

module sfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sfr_pkg::sfr_stat_t stat,
  output sfr_pkg::sfr_cmd_t      cmd
);
  import sfr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.accept = 1'b1;
          if (stat.match) begin
            if (!stat.rlen_zero) begin
              state_nxt = S_REPL;
            end else if (stat.in_last) begin
              state_nxt = S_MARK;
            end
          end else if (stat.in_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_REPL: begin
        cmd.emit      = stat.out_free;
        cmd.from_repl = 1'b1;
        if (stat.out_free && stat.idx_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN: begin
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.idx_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        cmd.mark = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("emission issued while the output register is occupied");
  a_mark_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> stat.out_free)
    else $error("end marker issued while the output register is occupied");
  a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> stat.last_q)
    else $error("flush running for a byte that was not the last one");
`endif

endmodule

`default_nettype wire

/* rtl/sfr_dp.sv */
`default_nettype none

module sfr_dp #(
  parameter int MAX_PATTERN     = 16,
  parameter int MAX_REPLACEMENT = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfr_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [sfr_pkg::BYTE_W-1:0]       in_byte,
  input  wire logic                             in_last,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]            out_byte,
  output logic                                  byte_valid,
  output logic                                  text_end,
  output logic                                  run_last,
  input  wire sfr_pkg::sfr_cmd_t                cmd,
  output sfr_pkg::sfr_stat_t                    stat
);
  import sfr_pkg::*;

  localparam int PAT_CAP = (MAX_PATTERN < SLOT_N) ? MAX_PATTERN : SLOT_N;
  localparam int REP_CAP = (MAX_REPLACEMENT < SLOT_N) ? MAX_REPLACEMENT : SLOT_N;

  // Configuration registers.
  logic [CFG_W-1:0] pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [CNT_W-1:0] plen_r, rlen_r;

  // Pending window and sequencing state.
  logic [BYTE_W-1:0] win_r   [PAT_CAP];
  logic [BYTE_W-1:0] win_nxt [PAT_CAP];
  logic [BYTE_W-1:0] app     [PAT_CAP];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              last_r, last_nxt;

  // Output register.
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              obv_r, obv_nxt;
  logic              oe_r, oe_nxt;
  logic              orl_r, orl_nxt;

  logic [2*CFG_W-1:0] pat_all, rep_all;
  logic [BYTE_W-1:0]  pat_b [SLOT_N];
  logic [BYTE_W-1:0]  rep_b [SLOT_N];
  logic [CNT_W-1:0]   plen_eff, hold, rlen_eff;
  logic               win_ok, match, pop, idx_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      plen_r   <= CNT_W'(1);
      rep_lo_r <= '0;
      rep_hi_r <= '0;
      rlen_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LO:  pat_lo_r <= cfg_data;
        CFG_PAT_HI:  pat_hi_r <= cfg_data;
        CFG_PAT_LEN: plen_r   <= cfg_data[CNT_W-1:0];
        CFG_REP_LO:  rep_lo_r <= cfg_data;
        CFG_REP_HI:  rep_hi_r <= cfg_data;
        CFG_REP_LEN: rlen_r   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_hi_r, pat_lo_r};
  assign rep_all = {rep_hi_r, rep_lo_r};

  always_comb begin
    for (int i = 0; i < SLOT_N; i++) begin
      pat_b[i] = pat_all[BYTE_W*i +: BYTE_W];
      rep_b[i] = rep_all[BYTE_W*i +: BYTE_W];
    end
  end

  always_comb begin
    if (plen_r == '0) begin
      plen_eff = CNT_W'(1);
    end else if (plen_r > CNT_W'(PAT_CAP)) begin
      plen_eff = CNT_W'(PAT_CAP);
    end else begin
      plen_eff = plen_r;
    end
    hold     = plen_eff - CNT_W'(1);
    rlen_eff = (rlen_r > CNT_W'(REP_CAP)) ? CNT_W'(REP_CAP) : rlen_r;
  end

  // A match needs a full window equal to the pattern head and the new byte
  // equal to the pattern tail.
  always_comb begin
    win_ok = 1'b1;
    for (int i = 0; i < PAT_CAP; i++) begin
      if ((CNT_W'(i) < hold) && (win_r[i] != pat_b[i])) begin
        win_ok = 1'b0;
      end
    end
    match = (count_r == hold) && win_ok && (in_byte == pat_b[hold[SLOT_W-1:0]]);
    pop   = (count_r == hold);
    for (int i = 0; i < PAT_CAP; i++) begin
      app[i] = (count_r == CNT_W'(i)) ? in_byte : win_r[i];
    end
  end

  assign idx_end = (idx_r == (total_r - CNT_W'(1)));

  always_comb begin
    win_nxt   = win_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    last_nxt  = last_r;
    ov_nxt    = out_ready ? 1'b0 : ov_r;
    ob_nxt    = ob_r;
    obv_nxt   = obv_r;
    oe_nxt    = oe_r;
    orl_nxt   = orl_r;

    if (cmd.accept) begin
      last_nxt = in_last;
      idx_nxt  = '0;
      if (match) begin
        count_nxt = '0;
        total_nxt = rlen_eff;
      end else if (in_last) begin
        win_nxt   = app;
        count_nxt = '0;
        total_nxt = count_r + CNT_W'(1);
      end else if (pop) begin
        // Full window: the oldest byte leaves in the same cycle.
        for (int i = 0; i < PAT_CAP - 1; i++) begin
          win_nxt[i] = app[i+1];
        end
        ov_nxt  = 1'b1;
        ob_nxt  = app[0];
        obv_nxt = 1'b1;
        oe_nxt  = 1'b0;
        orl_nxt = 1'b1;
      end else begin
        win_nxt   = app;
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (cmd.emit) begin
      ov_nxt  = 1'b1;
      ob_nxt  = cmd.from_repl ? rep_b[idx_r[SLOT_W-1:0]] : win_r[0];
      obv_nxt = 1'b1;
      oe_nxt  = idx_end && last_r;
      orl_nxt = idx_end;
      idx_nxt = idx_r + CNT_W'(1);
      if (!cmd.from_repl) begin
        for (int i = 0; i < PAT_CAP - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
      end
    end

    if (cmd.mark) begin
      ov_nxt  = 1'b1;
      ob_nxt  = '0;
      obv_nxt = 1'b0;
      oe_nxt  = 1'b1;
      orl_nxt = 1'b1;
    end

    // A new pattern length drops whatever is pending.
    if (cfg_we && (cfg_index == CFG_PAT_LEN)) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      total_r <= '0;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    ob_r  <= ob_nxt;
    obv_r <= obv_nxt;
    oe_r  <= oe_nxt;
    orl_r <= orl_nxt;
  end

  assign out_valid  = ov_r;
  assign out_byte   = ob_r;
  assign byte_valid = obv_r;
  assign text_end   = oe_r;
  assign run_last   = orl_r;

  assign stat.out_free  = !ov_r || out_ready;
  assign stat.in_last   = in_last;
  assign stat.match     = match;
  assign stat.rlen_zero = (rlen_eff == '0);
  assign stat.last_q    = last_r;
  assign stat.idx_end   = idx_end;

`ifndef SYNTHESIS
  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hold)
    else $error("pending count exceeds the window size");
  a_marker_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !obv_r) |-> (oe_r && orl_r))
    else $error("bare end marker without end flags");
  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (idx_r < total_r))
    else $error("emission beyond the burst length");
`endif

endmodule

`default_nettype wire

/* rtl/stream_find_and_replace_unit.sv */
// Streaming find and replace over a byte stream.
// in_ch carries one text byte per transaction (text_byte, text_last); out_ch
// carries one result per transaction (out_byte, byte_valid, text_end, run_last).
// Both use valid/ready; a transaction completes when both are high at a clock
// edge. The cfg_* port writes the pattern, its length, the replacement and
// its length, one register per cycle with cfg_we high; the user writes them
// only while the block idles, as the block does not enforce it. A byte that
// does not complete a match has its result, if any, in the output register on
// the next cycle: plain text moves at one byte per cycle while out_ch does not
// stall. The replacement and flush sequencer holds in_ch.ready low while
// a matching byte's replacement bytes or the final byte's window bytes go out.
// A match on the final byte with an empty replacement gives one bare end
// marker (byte_valid low). When out_ch stalls, the single output register
// holds its result and in_ch.ready follows, since a new byte may need it.
// Synchronous reset (rst_n low) empties the window, clears the output valid
// flag and restores the registers: pattern length 1, all else zero.
`default_nettype none

module stream_find_and_replace_unit #(
  parameter int MAX_PATTERN     = 16,
  parameter int MAX_REPLACEMENT = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sfr_in_if.sink                             in_ch,
  sfr_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::CFG_W-1:0]     cfg_data
);
  import sfr_pkg::*;

  sfr_cmd_t  cmd;
  sfr_stat_t stat;
  logic      in_ready;

  // Controller: accepts bytes and sequences replacement bursts, flushes and
  // end markers.
  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath: registers, pending window, match compare and output register.
  sfr_dp #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (in_ch.text_byte),
    .in_last    (in_ch.text_last),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .byte_valid (out_ch.byte_valid),
    .text_end   (out_ch.text_end),
    .run_last   (out_ch.run_last),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire

/* tb/sv/stream_find_and_replace_unit_tb.sv */
`default_nettype none

module stream_find_and_replace_unit_tb;
  import sfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block does not decode. Writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int RAND_ITEMS    = 120;
  // Consecutive cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT   = 1000;
  // Cycles to let a byte that makes no result settle before a register write.
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              text_end;
    logic              run_last;
  } text_result_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_TEXT
  } row_kind_t;

  // One line of the directed table. A text row with typed_n of -1 is checked
  // against the rewrite model; 0 or 1 means the expected result is given here.
  typedef struct {
    row_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]    reg_data;
    logic [BYTE_W-1:0]   text_byte;
    logic                text_last;
    int                  typed_n;
    text_result_t        typed_res;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();

  stream_find_and_replace_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the programmed registers, at their reset values.
  logic [CFG_W-1:0] pat_lo    = '0;
  logic [CFG_W-1:0] pat_hi    = '0;
  logic [CNT_W-1:0] pat_len_q = 5'd1;
  logic [CFG_W-1:0] rep_lo    = '0;
  logic [CFG_W-1:0] rep_hi    = '0;
  logic [CNT_W-1:0] rep_len_q = '0;

  // Bytes held back while they might still start a match.
  logic [BYTE_W-1:0] win [SLOT_N];
  int                win_cnt = 0;

  // Results of the latest text byte, and all results still owed by the block.
  text_result_t step_res [$];
  text_result_t rewritten_q [$];

  row_t directed_rows [$];

  int mismatch_cnt = 0;
  int stall_cycles = 0;
  int sink_hold    = 0;
  // Idle intensity per side: 0 none, 1 light, 2 heavy.
  int src_idle     = 0;
  int snk_idle     = 0;

  function automatic logic [BYTE_W-1:0] slot_byte(input logic [CFG_W-1:0] lo,
                                                  input logic [CFG_W-1:0] hi, input int i);
    if (i < 8) begin
      return lo[8*i +: 8];
    end
    return hi[8*(i-8) +: 8];
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
    case (idx)
      CFG_PAT_LO: pat_lo = data;
      CFG_PAT_HI: pat_hi = data;
      CFG_PAT_LEN: begin
        // A new pattern length throws away whatever was being held.
        pat_len_q = data[CNT_W-1:0];
        win_cnt   = 0;
      end
      CFG_REP_LO:  rep_lo = data;
      CFG_REP_HI:  rep_hi = data;
      CFG_REP_LEN: rep_len_q = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // Advances the find-and-replace state by one text byte and leaves the
  // results that byte causes in step_res.
  function automatic void rewrite_byte(input logic [BYTE_W-1:0] b, input logic last);
    int           plen;
    int           hold;
    int           rlen;
    bit           hit;
    text_result_t r;
    step_res.delete();
    plen = (pat_len_q == 0) ? 1 : ((pat_len_q > SLOT_N) ? SLOT_N : int'(pat_len_q));
    rlen = (rep_len_q > SLOT_N) ? SLOT_N : int'(rep_len_q);
    hold = plen - 1;
    if (win_cnt > hold) begin
      win_cnt = 0;
    end
    // A match needs a full window plus the new byte equal to the pattern.
    hit = (win_cnt == hold);
    if (hit) begin
      for (int i = 0; i < hold; i++) begin
        if (win[i] != slot_byte(pat_lo, pat_hi, i)) begin
          hit = 1'b0;
        end
      end
      if (b != slot_byte(pat_lo, pat_hi, hold)) begin
        hit = 1'b0;
      end
    end
    if (hit) begin
      for (int i = 0; i < rlen; i++) begin
        r = '{out_byte: slot_byte(rep_lo, rep_hi, i), byte_valid: 1'b1,
              text_end: 1'b0, run_last: 1'b0};
        step_res.push_back(r);
      end
      win_cnt = 0;
    end else begin
      win[win_cnt] = b;
      win_cnt++;
      // Window overflow: the oldest byte can no longer be part of a match.
      if (win_cnt > hold) begin
        r = '{out_byte: win[0], byte_valid: 1'b1, text_end: 1'b0, run_last: 1'b0};
        step_res.push_back(r);
        for (int j = 0; j < SLOT_N - 1; j++) begin
          win[j] = win[j+1];
        end
        win_cnt--;
      end
    end
    if (last) begin
      for (int i = 0; i < win_cnt; i++) begin
        r = '{out_byte: win[i], byte_valid: 1'b1, text_end: 1'b0, run_last: 1'b0};
        step_res.push_back(r);
      end
      win_cnt = 0;
      // The end of the text is always marked, by a bare marker if nothing else.
      if (step_res.size() == 0) begin
        r = '{out_byte: '0, byte_valid: 1'b0, text_end: 1'b0, run_last: 1'b0};
        step_res.push_back(r);
      end
      step_res[step_res.size()-1].text_end = 1'b1;
    end
    if (step_res.size() > 0) begin
      step_res[step_res.size()-1].run_last = 1'b1;
    end
  endfunction

  function automatic row_t wr_row(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
    row_t row;
    row = '{kind: ROW_WRITE, reg_idx: idx, reg_data: data, text_byte: '0,
            text_last: 1'b0, typed_n: -1, typed_res: '0};
    return row;
  endfunction

  function automatic row_t text_row(input logic [BYTE_W-1:0] b, input logic last,
                                    input int n, input text_result_t res);
    row_t row;
    row = '{kind: ROW_TEXT, reg_idx: '0, reg_data: '0, text_byte: b,
            text_last: last, typed_n: n, typed_res: res};
    return row;
  endfunction

  // Lowers valid and waits until the block owes nothing, then a few more
  // cycles in case the last byte produced no result but is still in flight.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (rewritten_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. With more set, the write enable stays high for the
  // write that follows in the next cycle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input bit more);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_cfg(idx, data);
    if (!more) begin
      cfg_we <= 1'b0;
    end
  endtask

  // Offers one text byte, possibly after an idle burst, and files the results
  // it owes once the transaction completes.
  task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic last,
                                input int typed_n, input text_result_t typed_res);
    int gap;
    if (src_idle != 0 && $urandom_range(0, (src_idle == 1) ? 7 : 2) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.text_byte <= b;
    in_if.text_last <= last;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    rewrite_byte(b, last);
    if (typed_n < 0) begin
      foreach (step_res[k]) begin
        rewritten_q.push_back(step_res[k]);
      end
    end else if (typed_n == 1) begin
      rewritten_q.push_back(typed_res);
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    mismatch_cnt++;
  endtask

  // Result side: stalls come in bursts while idling is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold = 0;
      out_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_if.ready <= 1'b0;
    end else if (snk_idle != 0 && $urandom_range(0, (snk_idle == 1) ? 7 : 2) == 0) begin
      sink_hold = $urandom_range(1, 16) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Every result transaction is compared with the oldest result still owed.
  always @(posedge clk) begin : check_results
    text_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (rewritten_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual byte %0h valid %0b end %0b last %0b",
                 $time, out_if.out_byte, out_if.byte_valid, out_if.text_end, out_if.run_last);
        mismatch_cnt++;
      end else begin
        want = rewritten_q.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          report_field("out_byte", want.out_byte, out_if.out_byte);
        end
        if (out_if.byte_valid !== want.byte_valid) begin
          report_field("byte_valid", want.byte_valid, out_if.byte_valid);
        end
        if (out_if.text_end !== want.text_end) begin
          report_field("text_end", want.text_end, out_if.text_end);
        end
        if (out_if.run_last !== want.run_last) begin
          report_field("run_last", want.run_last, out_if.run_last);
        end
      end
    end
  end

  // The run is hung if no transaction happens on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    row_t              row;
    logic [BYTE_W-1:0] pat_b [SLOT_N];
    logic [BYTE_W-1:0] sym [3];
    logic [BYTE_W-1:0] text_q [$];
    logic [CFG_W-1:0]  pat_lo_w;
    logic [CFG_W-1:0]  pat_hi_w;
    logic [CFG_W-1:0]  w_data;
    logic [CNT_W-1:0]  plen_w;
    logic [CNT_W-1:0]  rlen_w;
    int                eff;
    int                sel;
    int                n;
    int                cut;
    int                rand_bytes;
    bit                alpha;
    bit                noise;
    bit                tail;

    for (int i = 0; i < SLOT_N; i++) begin
      win[i] = '0;
    end
    in_if.valid     <= 1'b0;
    in_if.text_byte <= '0;
    in_if.text_last <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    rst_n           <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Straight after reset the pattern is the single byte
    // zero and the replacement is empty, so every zero byte is deleted.
    directed_rows.push_back(text_row(8'hFF, 1'b1, 1, '{8'hFF, 1'b1, 1'b1, 1'b1}));
    directed_rows.push_back(text_row(8'h00, 1'b0, 0, '0));
    // A match on the last byte with nothing to put out leaves a bare end marker.
    directed_rows.push_back(text_row(8'h00, 1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1}));
    // A pattern length of zero behaves as length one.
    directed_rows.push_back(wr_row(CFG_PAT_LO, 64'h0000_0000_0000_0041));
    directed_rows.push_back(wr_row(CFG_REP_LO, 64'h0000_0000_0000_A55A));
    directed_rows.push_back(wr_row(CFG_REP_LEN, 64'd2));
    directed_rows.push_back(wr_row(CFG_PAT_LEN, 64'd0));
    directed_rows.push_back(text_row(8'h41, 1'b0, -1, '0));
    directed_rows.push_back(text_row(8'h42, 1'b1, -1, '0));
    // Longest pattern and replacement, reached through oversized lengths that
    // must saturate, after a write to an undecoded index.
    directed_rows.push_back(wr_row(CFG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(wr_row(CFG_PAT_LO, 64'h0706_0504_0302_0100));
    directed_rows.push_back(wr_row(CFG_PAT_HI, 64'h0F0E_0D0C_0B0A_0908));
    directed_rows.push_back(wr_row(CFG_REP_LO, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(wr_row(CFG_REP_HI, 64'h8000_0000_0000_0001));
    directed_rows.push_back(wr_row(CFG_REP_LEN, 64'd17));
    directed_rows.push_back(wr_row(CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF));
    for (int i = 0; i < SLOT_N; i++) begin
      directed_rows.push_back(text_row(BYTE_W'(i), i == SLOT_N - 1, -1, '0));
    end
    // Changing the pattern length in the middle of a text drops the held bytes,
    // so the final byte comes out alone instead of completing the match.
    directed_rows.push_back(wr_row(CFG_SPARE_B, 64'h5555_AAAA_5555_AAAA));
    directed_rows.push_back(wr_row(CFG_PAT_LEN, 64'd3));
    directed_rows.push_back(text_row(8'h00, 1'b0, 0, '0));
    directed_rows.push_back(text_row(8'h01, 1'b0, 0, '0));
    directed_rows.push_back(wr_row(CFG_PAT_LEN, 64'd3));
    directed_rows.push_back(text_row(8'h02, 1'b1, 1, '{8'h02, 1'b1, 1'b1, 1'b1}));

    src_idle = 1;
    snk_idle = 1;
    for (int r = 0; r < directed_rows.size(); r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_WRITE) begin
        if (r == 0 || directed_rows[r-1].kind != ROW_WRITE) begin
          wait_drained();
        end
        write_reg(row.reg_idx, row.reg_data,
                  r + 1 < directed_rows.size() && directed_rows[r+1].kind == ROW_WRITE);
      end else begin
        send_text_byte(row.text_byte, row.text_last, row.typed_n, row.typed_res);
      end
    end

    // Random part: each phase programs a fresh setting and then streams a few
    // texts built mostly from pieces of the pattern, so that matches, near
    // misses and overlapping candidates are common. Phases that start in the last
    // fifth of the run have no idling on either side.
    rand_bytes = 0;
    while (rand_bytes < RAND_ITEMS) begin
      tail     = (rand_bytes >= RAND_ITEMS * 4 / 5);
      src_idle = tail ? 0 : $urandom_range(0, 2);
      snk_idle = tail ? 0 : $urandom_range(0, 2);

      // Mostly short patterns, sometimes zero, the maximum, or oversized.
      sel    = $urandom_range(0, 9);
      plen_w = (sel == 0) ? 5'd0 : (sel == 1) ? 5'd16 :
               (sel == 2) ? CNT_W'($urandom_range(17, 31)) : CNT_W'($urandom_range(1, 4));
      eff    = (plen_w == 0) ? 1 : (plen_w > SLOT_N) ? SLOT_N : int'(plen_w);
      sel    = $urandom_range(0, 9);
      rlen_w = (sel == 0) ? 5'd0 : (sel == 1) ? 5'd16 :
               (sel == 2) ? CNT_W'($urandom_range(17, 31)) : CNT_W'($urandom_range(0, 4));

      // A small alphabet makes the pattern repeat itself, which exercises
      // the leftmost, non-overlapping rule.
      alpha = $urandom_range(0, 1);
      for (int i = 0; i < 3; i++) begin
        sym[i] = $urandom_range(0, 255);
      end
      for (int i = 0; i < SLOT_N; i++) begin
        pat_b[i] = alpha ? sym[$urandom_range(0, 2)] : BYTE_W'($urandom_range(0, 255));
      end
      for (int i = 0; i < 8; i++) begin
        pat_lo_w[8*i +: 8] = pat_b[i];
        pat_hi_w[8*i +: 8] = pat_b[i+8];
      end

      wait_drained();
      write_reg(CFG_PAT_LO, pat_lo_w, 1'b1);
      write_reg(CFG_PAT_HI, pat_hi_w, 1'b1);
      // Length writes sometimes carry junk above the five decoded bits.
      w_data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      w_data[CNT_W-1:0] = plen_w;
      write_reg(CFG_PAT_LEN, w_data, 1'b1);
      write_reg(CFG_REP_LO, {$urandom, $urandom}, 1'b1);
      write_reg(CFG_REP_HI, {$urandom, $urandom}, 1'b1);
      w_data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      w_data[CNT_W-1:0] = rlen_w;
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_REP_LEN, w_data, 1'b1);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom}, 1'b0);
      end else begin
        write_reg(CFG_REP_LEN, w_data, 1'b0);
      end

      repeat ($urandom_range(2, 4)) begin
        text_q.delete();
        noise = ($urandom_range(0, 5) == 0);
        n     = $urandom_range(1, 14);
        while (text_q.size() < n) begin
          sel = noise ? 9 : $urandom_range(0, 9);
          if (sel < 5) begin
            for (int i = 0; i < eff; i++) begin
              text_q.push_back(pat_b[i]);
            end
          end else if (sel < 7) begin
            cut = $urandom_range(1, eff);
            for (int i = 0; i < cut; i++) begin
              text_q.push_back(pat_b[i]);
            end
          end else if (sel < 9) begin
            text_q.push_back(pat_b[$urandom_range(0, eff - 1)]);
          end else begin
            text_q.push_back(BYTE_W'($urandom_range(0, 255)));
          end
        end
        foreach (text_q[k]) begin
          // Now and then the sender holds off in mid text until the block
          // has delivered everything it owes.
          if (k > 0 && !tail && $urandom_range(0, 15) == 0) begin
            wait_drained();
          end
          send_text_byte(text_q[k], k == text_q.size() - 1, -1, '0);
          rand_bytes++;
        end
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && rewritten_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/sfr_ctrl.sv
rtl/sfr_dp.sv
rtl/stream_find_and_replace_unit.sv
tb/sv/stream_find_and_replace_unit_tb.sv
